@@ hw/rtl/prsu_pkg.sv @@
// Package with beat types, packing modes and group constants for the raw sample unpacker.
package prsu_pkg;

  typedef enum logic [1:0] {
    MODE_P12  = 2'd0,
    MODE_P14  = 2'd1,
    MODE_LE16 = 2'd2
  } mode_e;

  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] GroupLenP12  = 3'd3;
  localparam logic [PhaseW-1:0] GroupLenP14  = 3'd7;
  localparam logic [PhaseW-1:0] GroupLenLe16 = 3'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last_sample;
  } out_beat_t;

  typedef struct packed {
    logic              emit;
    out_beat_t         beat;
    logic [PhaseW-1:0] next_phase;
    logic [15:0]       next_held;
  } unpack_res_t;

endpackage

@@ hw/rtl/prsu_unpack.sv @@
// Combinational unpacking of one byte against the group phase and the held bytes.
module prsu_unpack (
  input  logic [1:0]                   mode_i,
  input  logic [prsu_pkg::PhaseW-1:0]  phase_i,
  input  logic [15:0]                  held_i,
  input  prsu_pkg::in_beat_t           beat_i,
  output prsu_pkg::unpack_res_t        res_o
);

  logic [prsu_pkg::PhaseW-1:0] len;
  logic [prsu_pkg::PhaseW-1:0] ph_raw;
  logic [prsu_pkg::PhaseW-1:0] ph;
  logic [prsu_pkg::PhaseW-1:0] ph_inc;
  logic [7:0]                  b;
  logic [7:0]                  p1;
  logic [7:0]                  p2;
  logic                        emit;
  logic [15:0]                 val;

  assign b      = beat_i.data_byte;
  assign p1     = held_i[7:0];
  assign p2     = held_i[15:8];
  assign ph_raw = beat_i.first_byte ? '0 : phase_i;
  assign ph     = (ph_raw >= len) ? '0 : ph_raw;
  assign ph_inc = ph + 3'd1;

  always_comb begin
    case (mode_i)
      prsu_pkg::MODE_P12: begin
        len = prsu_pkg::GroupLenP12;
      end
      prsu_pkg::MODE_P14: begin
        len = prsu_pkg::GroupLenP14;
      end
      default: begin
        len = prsu_pkg::GroupLenLe16;
      end
    endcase
  end

  always_comb begin
    emit = 1'b0;
    val  = '0;
    case (mode_i)
      prsu_pkg::MODE_P12: begin
        if (ph == 3'd1) begin
          emit = 1'b1;
          val  = {4'b0, p1, b[7:4]};
        end else if (ph == 3'd2) begin
          emit = 1'b1;
          val  = {4'b0, p1[3:0], b};
        end
      end
      prsu_pkg::MODE_P14: begin
        if (ph == 3'd1) begin
          emit = 1'b1;
          val  = {2'b0, p1, b[7:2]};
        end else if (ph == 3'd3) begin
          emit = 1'b1;
          val  = {2'b0, p2[1:0], p1, b[7:4]};
        end else if (ph == 3'd5) begin
          emit = 1'b1;
          val  = {2'b0, p2[3:0], p1, b[7:6]};
        end else if (ph == 3'd6) begin
          emit = 1'b1;
          val  = {2'b0, p1[5:0], b};
        end
      end
      default: begin
        if (ph == 3'd1) begin
          emit = 1'b1;
          val  = {b, p1};
        end
      end
    endcase
  end

  always_comb begin
    res_o                  = '0;
    res_o.emit             = emit;
    res_o.beat.sample      = val;
    res_o.beat.last_sample = beat_i.last_byte;
    res_o.next_held        = {p1, b};
    res_o.next_phase       = ((ph_inc >= len) || beat_i.last_byte) ? '0 : ph_inc;
  end

endmodule

@@ hw/rtl/prsu_out_stage.sv @@
// Result register that holds one sample beat until the receiver takes it.
module prsu_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  prsu_pkg::out_beat_t push_data_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prsu_pkg::out_beat_t out_data_o
);

  logic                valid_q;
  prsu_pkg::out_beat_t data_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_valid_i) begin
      data_q <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/packed_raw_sample_unpacker_unit.sv @@
// Top level of the packed raw sample unpacker with input register, state and result register.
// A sample is formed from the byte in the input register and is stored in the result register.
// One byte per cycle unless the result register stalls, set by the single input register.
// The input register advances whenever the result register is empty or being taken.
// Reset clears the packing mode to 12-bit, the group phase and the held bytes.
// Beats in flight are dropped at reset.
module packed_raw_sample_unpacker_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prsu_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prsu_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);

  logic [1:0]                  mode_q;
  logic [prsu_pkg::PhaseW-1:0] phase_q;
  logic [15:0]                 held_q;
  logic                        in_valid_q;
  prsu_pkg::in_beat_t          in_beat_q;
  prsu_pkg::unpack_res_t       res;
  logic                        adv;
  logic                        step;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = in_valid_q && !adv;
  assign step        = in_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= prsu_pkg::MODE_P12;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_beat_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
    end else if (step) begin
      phase_q <= res.next_phase;
      held_q  <= res.next_held;
    end
  end

  prsu_unpack u_unpack (
    .mode_i  (mode_q),
    .phase_i (phase_q),
    .held_i  (held_q),
    .beat_i  (in_beat_q),
    .res_o   (res)
  );

  prsu_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_q && res.emit),
    .push_data_i  (res.beat),
    .ready_o      (adv),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 3'd7)
    else $error("Group phase reached an impossible value.");

  a_stall_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("Input taken while the result register is blocked.");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(in_valid_q && res.emit)) |=> !out_valid_o)
    else $error("Result register kept a beat that was already taken.");

  a_p12_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_q == prsu_pkg::MODE_P12) |-> out_data_o.sample[15:12] == 4'b0)
    else $error("A 12-bit sample has upper bits set.");

  a_last_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_beat_q.last_byte) |=> phase_q == '0)
    else $error("Group phase not cleared after the last byte.");

endmodule

@@ tb/unpack_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard class that predicts unpacked raw samples and checks the ones the unpacker returns.
package unpack_check_pkg;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class sample_scoreboard;
    logic [1:0]          mode;
    logic [2:0]          phase;
    logic [15:0]         held;
    prsu_pkg::out_beat_t sample_q[$];
    int unsigned         mismatches;

    function new();
      mode       = prsu_pkg::MODE_P12;
      phase      = '0;
      held       = '0;
      mismatches = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int unsigned pending();
      return sample_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void note_input(prsu_pkg::in_beat_t b);
      logic [2:0]          len;
      logic [2:0]          ph;
      logic [2:0]          nxt;
      logic [7:0]          d;
      logic [7:0]          p1;
      logic [7:0]          p2;
      logic                emit;
      logic [15:0]         val;
      prsu_pkg::out_beat_t e;
      d    = b.data_byte;
      p1   = held[7:0];
      p2   = held[15:8];
      emit = 1'b1;
      val  = '0;
      case (mode)
        prsu_pkg::MODE_P12: len = prsu_pkg::GroupLenP12;
        prsu_pkg::MODE_P14: len = prsu_pkg::GroupLenP14;
        default:            len = prsu_pkg::GroupLenLe16;
      endcase
      ph = b.first_byte ? 3'd0 : phase;
      if (ph >= len) ph = 3'd0;
      case (mode)
        prsu_pkg::MODE_P12: begin
          if (ph == 3'd1) val = {4'h0, p1, d[7:4]};
          else if (ph == 3'd2) val = {4'h0, p1[3:0], d};
          else emit = 1'b0;
        end
        prsu_pkg::MODE_P14: begin
          if (ph == 3'd1) val = {2'b00, p1, d[7:2]};
          else if (ph == 3'd3) val = {2'b00, p2[1:0], p1, d[7:4]};
          else if (ph == 3'd5) val = {2'b00, p2[3:0], p1, d[7:6]};
          else if (ph == 3'd6) val = {2'b00, p1[5:0], d};
          else emit = 1'b0;
        end
        default: begin
          if (ph == 3'd1) val = {d, p1};
          else emit = 1'b0;
        end
      endcase
      held = {held[7:0], d};
      nxt  = ph + 3'd1;
      if (nxt >= len || b.last_byte) nxt = 3'd0;
      phase = nxt;
      if (emit) begin
        e.sample      = val;
        e.last_sample = b.last_byte;
        sample_q.push_back(e);
      end
    endfunction

    task check_result(prsu_pkg::out_beat_t got);
      prsu_pkg::out_beat_t e;
      if (sample_q.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %h", got.sample));
        return;
      end
      e = sample_q.pop_front();
      if (got.sample !== e.sample)
        report_mismatch($sformatf("sample %h, expected %h", got.sample, e.sample));
      if (got.last_sample !== e.last_sample)
        report_mismatch($sformatf("last_sample %b, expected %b on sample %h",
                                  got.last_sample, e.last_sample, e.sample));
    endtask
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench that streams raw image bytes through the unpacker in every packing mode.
module tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned ItemsPerPhase = 47;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  prsu_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  prsu_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_data  = prsu_pkg::MODE_P12;

  bit          steady      = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned idle_cycles = 0;

  unpack_check_pkg::sample_scoreboard sb = new();

  packed_raw_sample_unpacker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_mode(cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 8);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(8, 30);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || hold_req) return 0;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(logic [7:0] d, logic f, logic l);
    int unsigned gap;
    prsu_pkg::in_beat_t b;
    b.data_byte  = d;
    b.first_byte = f;
    b.last_byte  = l;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_image(int unsigned n, bit noisy);
    logic f;
    logic l;
    for (int unsigned i = 0; i < n; i++) begin
      f = noisy ? ($urandom_range(0, 3) == 0) : (i == 0);
      l = noisy ? ($urandom_range(0, 3) == 0) : (i == n - 1);
      send_byte(8'($urandom), f, l);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] m);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    logic [1:0]  m;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset mode is 12-bit; the third group is cut short by the last byte.
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b1, 1'b0);
    send_byte(8'h3c, 1'b0, 1'b1);
    send_byte(8'h81, 1'b0, 1'b0);

    configure(prsu_pkg::MODE_P14);
    for (int unsigned i = 0; i < 7; i++) send_byte((i % 2) ? 8'h00 : 8'hff, i == 0, 1'b0);
    for (int unsigned i = 0; i < 5; i++) send_byte(8'($urandom), i == 0, 1'b0);

    // The phase left at five is beyond the group of the unused mode code.
    configure(unpack_check_pkg::MODE_UNUSED);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      m = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      configure(m);
      if (p == 2) hold_req = 1'b1;
      if (p == 7) steady = 1'b1;
      sent = 0;
      if (p == 5) begin
        send_image(12, 1'b0);
        drain();
        sent = 12;
      end
      while (sent < ItemsPerPhase) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        send_image(n, $urandom_range(0, 9) < 2);
        sent += n;
      end
      steady = 1'b0;
    end

    drain();
    repeat (SettleCycles * 2) @(posedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
